// ===== rtl/core/aabb_affine_transform_defines.svh =====
// ----------------------------------------------------------------------------
// AABB affine transform assertion macros
// Shared concurrent assertion forms clocked on clk, disabled under reset.
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// consequent must hold in the cycle the antecedent holds
`define AAT_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aat assertion failed");

// property must hold at every edge out of reset
`define AAT_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("aat assertion failed");

`endif

// ===== rtl/core/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// AABB affine transform package
// Field widths, payload and configuration types, register codes.
// ----------------------------------------------------------------------------
package aat_pkg;

	localparam int COORD_W            = 32;
	localparam int COEF_W             = 16;
	localparam int REG_W              = 48;
	localparam int NUM_AXES           = 3;
	localparam int CFG_IDX_W          = 3;
	localparam int COEF_FRAC_BITS_DEF = 14;

	localparam logic [REG_W-1:0]   ROW_X_RST = 48'd16384;
	localparam logic [REG_W-1:0]   ROW_Y_RST = 48'd1073741824;
	localparam logic [REG_W-1:0]   ROW_Z_RST = 48'd70368744177664;
	localparam logic [COORD_W-1:0] SHIFT_RST = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_X   = 3'd0,
		REG_ROW_Y   = 3'd1,
		REG_ROW_Z   = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic                      box_valid;
	} box_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_min_x;
		logic signed [COORD_W-1:0] new_min_y;
		logic signed [COORD_W-1:0] new_min_z;
		logic signed [COORD_W-1:0] new_max_x;
		logic signed [COORD_W-1:0] new_max_y;
		logic signed [COORD_W-1:0] new_max_z;
		logic                      out_valid;
	} box_out_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][REG_W-1:0]   rows;
		logic [NUM_AXES-1:0][COORD_W-1:0] shifts;
	} cfg_t;

	typedef struct packed {
		logic v;
		logic bv;
	} stg_ctrl_t;

	typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec3_t;

	function automatic logic signed [COEF_W-1:0] coef_of(input logic [REG_W-1:0] row,
		input logic [1:0] lane);
		coef_of = $signed(row[lane*COEF_W +: COEF_W]);
	endfunction

endpackage

// ===== rtl/core/aat_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// AABB affine transform configuration registers
// Coefficient rows and translation, written through a plain write port.
// ----------------------------------------------------------------------------
module aat_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aat_pkg::REG_W-1:0]     cfg_wdata,
	output aat_pkg::cfg_t                 cfg
);
	import aat_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows[0]   <= ROW_X_RST;
			cfg_q.rows[1]   <= ROW_Y_RST;
			cfg_q.rows[2]   <= ROW_Z_RST;
			cfg_q.shifts[0] <= SHIFT_RST;
			cfg_q.shifts[1] <= SHIFT_RST;
			cfg_q.shifts[2] <= SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_ROW_X:   cfg_q.rows[0]   <= cfg_wdata;
				REG_ROW_Y:   cfg_q.rows[1]   <= cfg_wdata;
				REG_ROW_Z:   cfg_q.rows[2]   <= cfg_wdata;
				REG_SHIFT_X: cfg_q.shifts[0] <= cfg_wdata[COORD_W-1:0];
				REG_SHIFT_Y: cfg_q.shifts[1] <= cfg_wdata[COORD_W-1:0];
				REG_SHIFT_Z: cfg_q.shifts[2] <= cfg_wdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/aat_split.sv =====
// ----------------------------------------------------------------------------
// AABB affine transform center/extent stage
// Register stage 1: box center and half-extent, floor-halved.
// ----------------------------------------------------------------------------
module aat_split (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  aat_pkg::box_in_t   box,
	output aat_pkg::stg_ctrl_t ctrl_s1,
	output aat_pkg::vec3_t     ctr_s1,
	output aat_pkg::vec3_t     ext_s1
);
	import aat_pkg::*;

	logic signed [COORD_W-1:0] lo [NUM_AXES];
	logic signed [COORD_W-1:0] hi [NUM_AXES];
	logic signed [COORD_W:0]   sum_w [NUM_AXES];
	logic signed [COORD_W:0]   dif_w [NUM_AXES];
	vec3_t                     ctr_d;
	vec3_t                     ext_d;

	assign lo[0] = box.min_x;
	assign lo[1] = box.min_y;
	assign lo[2] = box.min_z;
	assign hi[0] = box.max_x;
	assign hi[1] = box.max_y;
	assign hi[2] = box.max_z;

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			sum_w[a] = (COORD_W+1)'(hi[a]) + (COORD_W+1)'(lo[a]);
			dif_w[a] = (COORD_W+1)'(hi[a]) - (COORD_W+1)'(lo[a]);
			ctr_d[a] = sum_w[a][COORD_W:1];
			ext_d[a] = dif_w[a][COORD_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.v  <= accept;
			ctrl_s1.bv <= accept & box.box_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctr_s1 <= ctr_d;
		ext_s1 <= ext_d;
	end

endmodule

// ===== rtl/core/aat_mac.sv =====
// ----------------------------------------------------------------------------
// AABB affine transform multiply-accumulate
// Stage 2: eighteen truncated coordinate-coefficient products.
// Stage 3: center sums with translation, extent sums of magnitudes.
// ----------------------------------------------------------------------------
module aat_mac #(
	parameter int COEF_FRAC_BITS = aat_pkg::COEF_FRAC_BITS_DEF,
	parameter int SUM_W          = aat_pkg::COORD_W + aat_pkg::COEF_W - COEF_FRAC_BITS + 2
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  aat_pkg::cfg_t                             cfg,
	input  aat_pkg::stg_ctrl_t                        ctrl_s1,
	input  aat_pkg::vec3_t                            ctr_s1,
	input  aat_pkg::vec3_t                            ext_s1,
	output aat_pkg::stg_ctrl_t                        ctrl_s3,
	output logic [aat_pkg::NUM_AXES-1:0][SUM_W-1:0]   nc_s3,
	output logic [aat_pkg::NUM_AXES-1:0][SUM_W-1:0]   ne_s3
);
	import aat_pkg::*;

	localparam int PROD_W = COORD_W + COEF_W;
	localparam int TR_W   = PROD_W - COEF_FRAC_BITS;

	stg_ctrl_t                 ctrl_s2;
	logic signed [PROD_W-1:0]  pc_full [NUM_AXES][NUM_AXES];
	logic signed [PROD_W-1:0]  pe_full [NUM_AXES][NUM_AXES];
	logic [TR_W-1:0]           pc_s2 [NUM_AXES][NUM_AXES];
	logic [TR_W-1:0]           pe_s2 [NUM_AXES][NUM_AXES];
	logic signed [SUM_W-1:0]   pe_x [NUM_AXES][NUM_AXES];
	logic signed [SUM_W-1:0]   pe_abs [NUM_AXES][NUM_AXES];
	logic [NUM_AXES-1:0][SUM_W-1:0] nc_d;
	logic [NUM_AXES-1:0][SUM_W-1:0] ne_d;

	// products, row a times lane j
	always_comb begin
		for (int j = 0; j < NUM_AXES; j++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pc_full[j][a] = $signed(ctr_s1[a]) * coef_of(cfg.rows[a], 2'(j));
				pe_full[j][a] = $signed(ext_s1[a]) * coef_of(cfg.rows[a], 2'(j));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NUM_AXES; j++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pc_s2[j][a] <= pc_full[j][a][PROD_W-1:COEF_FRAC_BITS];
				pe_s2[j][a] <= pe_full[j][a][PROD_W-1:COEF_FRAC_BITS];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_AXES; j++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pe_x[j][a]   = SUM_W'($signed(pe_s2[j][a]));
				pe_abs[j][a] = pe_x[j][a][SUM_W-1] ? -pe_x[j][a] : pe_x[j][a];
			end
			nc_d[j] = SUM_W'($signed(pc_s2[j][0])) + SUM_W'($signed(pc_s2[j][1]))
				+ SUM_W'($signed(pc_s2[j][2])) + SUM_W'($signed(cfg.shifts[j]));
			ne_d[j] = pe_abs[j][0] + pe_abs[j][1] + pe_abs[j][2];
		end
	end

	always_ff @(posedge clk) begin
		nc_s3 <= nc_d;
		ne_s3 <= ne_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

endmodule

// ===== rtl/core/aat_corner.sv =====
// ----------------------------------------------------------------------------
// AABB affine transform corner stage
// Stage 4: center minus and plus extent, saturated, zeroed for empty boxes.
// ----------------------------------------------------------------------------
module aat_corner #(
	parameter int SUM_W = aat_pkg::COORD_W + aat_pkg::COEF_W - aat_pkg::COEF_FRAC_BITS_DEF + 2
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  aat_pkg::stg_ctrl_t                      ctrl_s3,
	input  logic [aat_pkg::NUM_AXES-1:0][SUM_W-1:0] nc_s3,
	input  logic [aat_pkg::NUM_AXES-1:0][SUM_W-1:0] ne_s3,
	output logic                                    done,
	output aat_pkg::box_out_t                       result
);
	import aat_pkg::*;

	localparam int LW = SUM_W + 1;

	logic signed [LW-1:0]      lo_w [NUM_AXES];
	logic signed [LW-1:0]      hi_w [NUM_AXES];
	logic [COORD_W-1:0]        mn [NUM_AXES];
	logic [COORD_W-1:0]        mx [NUM_AXES];
	box_out_t                  res_d;
	box_out_t                  result_s4;
	logic                      done_s4;

	function automatic logic [COORD_W-1:0] sat(input logic signed [LW-1:0] v);
		logic [LW-COORD_W:0] top;
		top = v[LW-1:COORD_W-1];
		if ((&top) || !(|top))
			sat = v[COORD_W-1:0];
		else if (v[LW-1])
			sat = {1'b1, {(COORD_W-1){1'b0}}};
		else
			sat = {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	always_comb begin
		for (int j = 0; j < NUM_AXES; j++) begin
			lo_w[j] = LW'($signed(nc_s3[j])) - LW'($signed(ne_s3[j]));
			hi_w[j] = LW'($signed(nc_s3[j])) + LW'($signed(ne_s3[j]));
			mn[j]   = ctrl_s3.bv ? sat(lo_w[j]) : '0;
			mx[j]   = ctrl_s3.bv ? sat(hi_w[j]) : '0;
		end
		res_d.new_min_x = mn[0];
		res_d.new_min_y = mn[1];
		res_d.new_min_z = mn[2];
		res_d.new_max_x = mx[0];
		res_d.new_max_y = mx[1];
		res_d.new_max_z = mx[2];
		res_d.out_valid = ctrl_s3.bv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= ctrl_s3.v;
		end
	end

	always_ff @(posedge clk) begin
		result_s4 <= res_d;
	end

	assign done   = done_s4;
	assign result = result_s4;

endmodule

// ===== rtl/core/aabb_affine_transform.sv =====
// ----------------------------------------------------------------------------
// AABB affine transform
// Bounds a transformed axis-aligned box by center/half-extent mapping.
// ----------------------------------------------------------------------------
// One box is taken per clock whenever start is high; busy never rises, so
// boxes may stream back to back without gaps. Each box gives exactly one
// result, shown on result for one cycle with done high once the box has
// passed the register stages. Results leave in arrival order and the
// receiver must take each one in that cycle, it cannot hold them off. The
// pipeline has four register stages: center and extent, the eighteen
// parallel 32x16 multipliers, the center and extent adders, and the corner
// saturation. Configuration writes take effect at the next edge and belong
// only to times when no box is in flight.
`include "aabb_affine_transform_defines.svh"

module aabb_affine_transform #(
	parameter int COEF_FRAC_BITS = aat_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  aat_pkg::box_in_t              box,
	output logic                          done,
	output aat_pkg::box_out_t             result,
	input  logic                          cfg_we,
	input  logic [aat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aat_pkg::REG_W-1:0]     cfg_wdata
);
	import aat_pkg::*;

	localparam int SUM_W = COORD_W + COEF_W - COEF_FRAC_BITS + 2;

	cfg_t                           cfg;
	stg_ctrl_t                      ctrl_s1;
	stg_ctrl_t                      ctrl_s3;
	vec3_t                          ctr_s1;
	vec3_t                          ext_s1;
	logic [NUM_AXES-1:0][SUM_W-1:0] nc_s3;
	logic [NUM_AXES-1:0][SUM_W-1:0] ne_s3;
	logic                           accept;
	logic                           corners_ok;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	aat_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	aat_split u_split (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.box     (box),
		.ctrl_s1 (ctrl_s1),
		.ctr_s1  (ctr_s1),
		.ext_s1  (ext_s1)
	);

	aat_mac #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.SUM_W          (SUM_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.ctrl_s1 (ctrl_s1),
		.ctr_s1  (ctr_s1),
		.ext_s1  (ext_s1),
		.ctrl_s3 (ctrl_s3),
		.nc_s3   (nc_s3),
		.ne_s3   (ne_s3)
	);

	aat_corner #(
		.SUM_W (SUM_W)
	) u_corner (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s3 (ctrl_s3),
		.nc_s3   (nc_s3),
		.ne_s3   (ne_s3),
		.done    (done),
		.result  (result)
	);

	assign corners_ok = (result.new_min_x <= result.new_max_x)
		&& (result.new_min_y <= result.new_max_y)
		&& (result.new_min_z <= result.new_max_z);

	`AAT_ASSERT_IMPL(a_done_follows_transfer, done, $past(accept, 4))
	`AAT_ASSERT_IMPL(a_valid_tracks_input, done, result.out_valid == $past(box.box_valid, 4))
	`AAT_ASSERT_IMPL(a_corners_ordered, done && result.out_valid, corners_ok)

endmodule
